/* src/qfrm_pkg.sv */
`timescale 1ns / 1ps
// shared constants, types and step functions for the matrix to quaternion pipeline
package qfrm_pkg;

  localparam int unsigned FracBits       = 14;
  localparam int unsigned Wq             = 30;
  localparam int unsigned CordicStepsDef = 16;

  localparam int unsigned InW   = 16;
  localparam int unsigned AngOW = 15;
  localparam int unsigned C2W   = FracBits + 3;
  localparam int unsigned DW    = InW + 1;
  localparam int unsigned UW    = 2 * FracBits + 3;

  localparam int unsigned RadW      = 62;
  localparam int unsigned RootW     = RadW / 2;
  localparam int unsigned RemW      = RootW + 2;
  localparam int unsigned SqrtSteps = RadW / 2;

  localparam int unsigned CordW = 34;
  localparam int unsigned AngW  = 35;

  localparam int unsigned DivW   = 31;
  localparam int unsigned DenW   = 32;
  localparam int unsigned QSteps = FracBits + 1;
  localparam int unsigned NqW    = DenW + QSteps;
  localparam int unsigned PW     = 48;

  localparam logic signed [AngW-1:0] PiW     = 35'sd3373259426;
  localparam logic signed [AngW-1:0] HalfPiW = 35'sd1686629713;
  localparam logic [InW-1:0]         QOne    = InW'(1 << FracBits);

  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
    logic [RadW-1:0]  rad;
  } sqrt_t;

  typedef struct packed {
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic signed [AngW-1:0]  z;
  } cordic_t;

  typedef struct packed {
    logic [DenW-1:0] den;
    logic [DenW-1:0] rem;
    logic [DivW-1:0] nq;
  } div_t;

  typedef struct packed {
    logic signed [C2W-1:0] c2;
    logic [2:0][DW-1:0]    d;
    logic [RootW-1:0]      s;
    logic [AngOW-1:0]      angle;
    logic [RootW-1:0]      ax;
    logic [RootW-1:0]      ay;
    logic                  sx;
    logic                  sy;
    logic [InW-1:0]        w;
    logic [2:0]            qsign;
    logic [2:0]            qsat;
  } side_t;

  // atan(2^-i) in q.30
  function automatic logic signed [AngW-1:0] atan_lut(input int unsigned idx);
    logic [29:0] v;
    case (idx)
      0:  v = 30'h3243F6A8;
      1:  v = 30'h1DAC6705;
      2:  v = 30'h0FADBAFC;
      3:  v = 30'h07F56EA6;
      4:  v = 30'h03FEAB76;
      5:  v = 30'h01FFD55B;
      6:  v = 30'h00FFFAAA;
      7:  v = 30'h007FFF55;
      8:  v = 30'h003FFFEA;
      9:  v = 30'h001FFFFD;
      10: v = 30'h000FFFFF;
      11: v = 30'h0007FFFF;
      12: v = 30'h0003FFFF;
      13: v = 30'h0001FFFF;
      14: v = 30'h0000FFFF;
      15: v = 30'h00007FFF;
      16: v = 30'h00003FFF;
      17: v = 30'h00001FFF;
      18: v = 30'h00000FFF;
      19: v = 30'h000007FF;
      20: v = 30'h000003FF;
      21: v = 30'h000001FF;
      22: v = 30'h000000FF;
      23: v = 30'h0000007F;
      24: v = 30'h0000003F;
      25: v = 30'h0000001F;
      26: v = 30'h0000000F;
      27: v = 30'h00000008;
      28: v = 30'h00000004;
      29: v = 30'h00000002;
      30: v = 30'h00000001;
      default: v = '0;
    endcase
    return $signed({{(AngW-30){1'b0}}, v});
  endfunction

  // one result bit of the digit by digit square root
  function automatic sqrt_t sqrt_step(input sqrt_t a);
    logic [RemW+1:0] t;
    logic [RemW-1:0] trial;
    sqrt_t r;
    t     = {a.rem, a.rad[RadW-1 -: 2]};
    trial = {a.root, 2'b01};
    r.rad = a.rad << 2;
    if (t >= {2'b00, trial}) begin
      r.rem  = RemW'(t - {2'b00, trial});
      r.root = {a.root[RootW-2:0], 1'b1};
    end else begin
      r.rem  = t[RemW-1:0];
      r.root = {a.root[RootW-2:0], 1'b0};
    end
    return r;
  endfunction

  // one quotient bit of restoring division, quotient shifts in behind the numerator
  function automatic div_t div_step(input div_t a);
    logic [DenW:0] t;
    div_t r;
    t     = {a.rem, a.nq[DivW-1]};
    r.den = a.den;
    if (t >= {1'b0, a.den}) begin
      r.rem = DenW'(t - {1'b0, a.den});
      r.nq  = {a.nq[DivW-2:0], 1'b1};
    end else begin
      r.rem = t[DenW-1:0];
      r.nq  = {a.nq[DivW-2:0], 1'b0};
    end
    return r;
  endfunction

  // vectoring micro-rotation, drives y towards zero
  function automatic cordic_t cordic_vec(input cordic_t a, input int unsigned sh);
    logic signed [CordW-1:0] dx;
    logic signed [CordW-1:0] dy;
    cordic_t r;
    dx = a.y >>> sh;
    dy = a.x >>> sh;
    if (a.y > 0) begin
      r.x = a.x + dx;
      r.y = a.y - dy;
      r.z = a.z + atan_lut(sh);
    end else begin
      r.x = a.x - dx;
      r.y = a.y + dy;
      r.z = a.z - atan_lut(sh);
    end
    return r;
  endfunction

  // rotation micro-rotation, drives the residual angle towards zero
  function automatic cordic_t cordic_rot(input cordic_t a, input int unsigned sh);
    logic signed [CordW-1:0] dx;
    logic signed [CordW-1:0] dy;
    cordic_t r;
    dx = a.y >>> sh;
    dy = a.x >>> sh;
    if (a.z >= 0) begin
      r.x = a.x - dx;
      r.y = a.y + dy;
      r.z = a.z - atan_lut(sh);
    end else begin
      r.x = a.x + dx;
      r.y = a.y - dy;
      r.z = a.z + atan_lut(sh);
    end
    return r;
  endfunction

endpackage

/* src/quaternion_from_rotation_matrix.sv */
`timescale 1ns / 1ps
// rotation matrix to quaternion, fully pipelined through square roots, cordic and dividers
//
//   channel | signals                            | direction
//   --------+------------------------------------+----------
//   in      | in_valid_i in_stall_o r00_i..r22_i | matrix in
//   out     | out_valid_o out_stall_i quat_*_o   | result out
//           | angle_o degenerate_o               |
//
// one item per cycle while no stalled result holds the pipe; the pipe is built from
// two 31 stage square roots, two cordic chains and 31 + 15 stage dividers
// every stage moves together; a stalled result holds the whole pipe and in_stall_o
// rises in the same cycle, so nothing in flight is dropped
// reset clears only the valid bits
module quaternion_from_rotation_matrix import qfrm_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CordicStepsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic signed [InW-1:0] r00_i,
  input  logic signed [InW-1:0] r01_i,
  input  logic signed [InW-1:0] r02_i,
  input  logic signed [InW-1:0] r10_i,
  input  logic signed [InW-1:0] r11_i,
  input  logic signed [InW-1:0] r12_i,
  input  logic signed [InW-1:0] r20_i,
  input  logic signed [InW-1:0] r21_i,
  input  logic signed [InW-1:0] r22_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [InW-1:0] quat_w_o,
  output logic signed [InW-1:0] quat_x_o,
  output logic signed [InW-1:0] quat_y_o,
  output logic signed [InW-1:0] quat_z_o,
  output logic [AngOW-1:0]      angle_o,
  output logic                  degenerate_o
);

  localparam int unsigned SqBase  = 2;
  localparam int unsigned VecBase = SqBase + SqrtSteps;
  localparam int unsigned EStage  = VecBase + CORDIC_STEPS;
  localparam int unsigned RotBase = EStage + 1;
  localparam int unsigned GStage  = RotBase + CORDIC_STEPS;
  localparam int unsigned HStage  = GStage + 1;
  localparam int unsigned Sq2Base = HStage + 1;
  localparam int unsigned PStage  = Sq2Base + SqrtSteps;
  localparam int unsigned DvBase  = PStage + 1;
  localparam int unsigned MStage  = DvBase + DivW;
  localparam int unsigned KStage  = MStage + 1;
  localparam int unsigned DqBase  = KStage + 1;
  localparam int unsigned OStage  = DqBase + QSteps;
  localparam int unsigned Depth   = OStage + 1;

  logic             adv;
  logic [Depth-1:0] valid_q;
  side_t            side_q [OStage];
  side_t            side_d [OStage];

  logic [UW-1:0] u_q;
  sqrt_t         sq1_q [SqrtSteps];
  cordic_t       vec_q [CORDIC_STEPS];
  logic signed [AngW-1:0] half_q;
  cordic_t       rot_q [CORDIC_STEPS];
  logic [2*RootW-1:0] xx_q, yy_q;
  logic [RadW-1:0]    sum_q;
  sqrt_t         sq2_q [SqrtSteps];
  div_t          pdx_q, pdy_q;
  div_t          dvx_q [DivW];
  div_t          dvy_q [DivW];
  logic signed [PW-1:0] prod_q [3];
  div_t          kd_q [3];
  div_t          dq_q [QSteps][3];

  logic signed [InW-1:0] quat_w_q, quat_x_q, quat_y_q, quat_z_q;
  logic [AngOW-1:0]      angle_q;
  logic                  degen_q;

  assign adv        = !(valid_q[Depth-1] && out_stall_i);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[Depth-2:0], in_valid_i};
    end
  end

  // ---------------------------------------------------------------- input stage
  logic signed [InW+1:0] tr_sum;
  logic signed [C2W-1:0] c2_in;

  always_comb begin
    tr_sum = (InW+2)'(r00_i) + (InW+2)'(r11_i) + (InW+2)'(r22_i)
             - $signed((InW+2)'(1 << FracBits));
    if (tr_sum > $signed((InW+2)'(2 << FracBits))) begin
      c2_in = $signed(C2W'(2 << FracBits));
    end else if (tr_sum < -$signed((InW+2)'(2 << FracBits))) begin
      c2_in = -$signed(C2W'(2 << FracBits));
    end else begin
      c2_in = C2W'(tr_sum);
    end
  end

  // ---------------------------------------------------------------- derived values
  logic signed [2*C2W-1:0] c2sq;
  cordic_t                 vec_init;
  logic signed [CordW-1:0] c_full;
  logic signed [CordW-1:0] s_full;
  logic signed [AngW-1:0]  z_end;
  logic signed [AngW-1:0]  z_clamped;
  logic [AngW-1:0]         ang_round;
  logic signed [CordW-1:0] rx, ry;
  logic [CordW-1:0]        rx_abs, ry_abs;
  logic [DenW-1:0]         mag_den;
  logic [RadW-1:0]         nx, ny;
  logic [DivW-1:0]         qx, qy;
  logic [DenW-1:0]         w_mag;
  logic [InW-1:0]          w_sat;
  logic signed [DenW-1:0]  sw;

  assign c2sq = side_q[0].c2 * side_q[0].c2;

  always_comb begin
    c_full = CordW'(side_q[VecBase-1].c2) <<< (Wq - FracBits - 1);
    s_full = $signed({{(CordW-RootW){1'b0}}, sq1_q[SqrtSteps-1].root});
    if (c_full >= 0) begin
      vec_init = '{x: c_full, y: s_full, z: '0};
    end else begin
      vec_init = '{x: s_full, y: -c_full, z: HalfPiW};
    end
  end

  // angle is limited to [0, pi] before halving
  always_comb begin
    z_end = vec_q[CORDIC_STEPS-1].z;
    if (z_end < 0) begin
      z_clamped = '0;
    end else if (z_end > PiW) begin
      z_clamped = PiW;
    end else begin
      z_clamped = z_end;
    end
    ang_round = (AngW'(z_clamped) + AngW'(1 << (Wq - FracBits))) >> (Wq - FracBits + 1);
  end

  always_comb begin
    rx     = rot_q[CORDIC_STEPS-1].x;
    ry     = rot_q[CORDIC_STEPS-1].y;
    rx_abs = (rx < 0) ? CordW'(-rx) : CordW'(rx);
    ry_abs = (ry < 0) ? CordW'(-ry) : CordW'(ry);
  end

  // normaliser: round(|v| * 2^30 / mag), a zero length counts as one
  always_comb begin
    mag_den = (sq2_q[SqrtSteps-1].root == '0) ? DenW'(1) : DenW'(sq2_q[SqrtSteps-1].root);
    nx = (RadW'(side_q[PStage-1].ax) << Wq) + RadW'(mag_den >> 1);
    ny = (RadW'(side_q[PStage-1].ay) << Wq) + RadW'(mag_den >> 1);
  end

  always_comb begin
    qx    = dvx_q[DivW-1].nq;
    qy    = dvy_q[DivW-1].nq;
    w_mag = (DenW'(qx) + DenW'(1 << (Wq - FracBits - 1))) >> (Wq - FracBits);
    w_sat = (w_mag > DenW'(QOne)) ? QOne : InW'(w_mag);
    sw    = side_q[MStage-1].sy ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
  end

  function automatic logic kd_q_sat(input logic signed [PW-1:0] p, input logic [RootW-1:0] s);
    logic [NqW-1:0] n;
    n = NqW'((p < 0) ? -p : p) + NqW'(s);
    return n[NqW-1 -: DenW] >= {s, 1'b0};
  endfunction

  function automatic div_t kd_init(input logic signed [PW-1:0] p, input logic [RootW-1:0] s);
    logic [NqW-1:0] n;
    div_t r;
    n     = NqW'((p < 0) ? -p : p) + NqW'(s);
    r.den = {s, 1'b0};
    r.rem = n[NqW-1 -: DenW];
    r.nq  = {n[QSteps-1:0], {(DivW-QSteps){1'b0}}};
    return r;
  endfunction

  // ---------------------------------------------------------------- side band
  always_comb begin
    side_d[0].c2    = c2_in;
    side_d[0].d[0]  = DW'(r21_i) - DW'(r12_i);
    side_d[0].d[1]  = DW'(r02_i) - DW'(r20_i);
    side_d[0].d[2]  = DW'(r10_i) - DW'(r01_i);
    side_d[0].s     = '0;
    side_d[0].angle = '0;
    side_d[0].ax    = '0;
    side_d[0].ay    = '0;
    side_d[0].sx    = 1'b0;
    side_d[0].sy    = 1'b0;
    side_d[0].w     = '0;
    side_d[0].qsign = '0;
    side_d[0].qsat  = '0;
    for (int unsigned k = 1; k < OStage; k++) begin
      side_d[k] = side_q[k-1];
    end
    side_d[VecBase].s     = sq1_q[SqrtSteps-1].root;
    side_d[EStage].angle  = ang_round[AngOW-1:0];
    side_d[GStage].ax     = rx_abs[RootW-1:0];
    side_d[GStage].ay     = ry_abs[RootW-1:0];
    side_d[GStage].sx     = rx < 0;
    side_d[GStage].sy     = ry < 0;
    side_d[MStage].w      = side_q[MStage-1].sx ? -w_sat : w_sat;
    for (int unsigned k = 0; k < 3; k++) begin
      side_d[KStage].qsign[k] = prod_q[k] < 0;
      side_d[KStage].qsat[k]  = kd_q_sat(prod_q[k], side_q[KStage-1].s);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q <= side_d;
      u_q    <= (UW'(1) << (2 * FracBits + 2)) - UW'(c2sq);
      half_q <= z_clamped >>> 1;
      xx_q   <= rx_abs[RootW-1:0] * rx_abs[RootW-1:0];
      yy_q   <= ry_abs[RootW-1:0] * ry_abs[RootW-1:0];
      sum_q  <= RadW'(xx_q) + RadW'(yy_q);
      pdx_q  <= '{den: mag_den, rem: DenW'(nx[RadW-1:DivW]), nq: nx[DivW-1:0]};
      pdy_q  <= '{den: mag_den, rem: DenW'(ny[RadW-1:DivW]), nq: ny[DivW-1:0]};
      for (int unsigned k = 0; k < 3; k++) begin
        prod_q[k] <= PW'($signed(side_q[MStage-1].d[k])) * PW'(sw);
        kd_q[k]   <= kd_init(prod_q[k], side_q[KStage-1].s);
      end
    end
  end

  // ---------------------------------------------------------------- sin(angle) root
  for (genvar g = 0; g < SqrtSteps; g++) begin : g_sq1
    sqrt_t st_in;
    if (g == 0) begin : g_first
      assign st_in = '{rem: '0, root: '0,
                       rad: RadW'(u_q) << (2 * (Wq - FracBits - 1))};
    end else begin : g_next
      assign st_in = sq1_q[g-1];
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq1_q[g] <= sqrt_step(st_in);
      end
    end
  end

  // ---------------------------------------------------------------- angle of (cos, sin)
  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_vec
    cordic_t st_in;
    if (g == 0) begin : g_first
      assign st_in = vec_init;
    end else begin : g_next
      assign st_in = vec_q[g-1];
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        vec_q[g] <= cordic_vec(st_in, g);
      end
    end
  end

  // ---------------------------------------------------------------- cos/sin of half angle
  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_rot
    cordic_t st_in;
    if (g == 0) begin : g_first
      assign st_in = '{x: CordW'(1) << Wq, y: '0, z: half_q};
    end else begin : g_next
      assign st_in = rot_q[g-1];
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        rot_q[g] <= cordic_rot(st_in, g);
      end
    end
  end

  // ---------------------------------------------------------------- length of rotated vector
  for (genvar g = 0; g < SqrtSteps; g++) begin : g_sq2
    sqrt_t st_in;
    if (g == 0) begin : g_first
      assign st_in = '{rem: '0, root: '0, rad: sum_q};
    end else begin : g_next
      assign st_in = sq2_q[g-1];
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq2_q[g] <= sqrt_step(st_in);
      end
    end
  end

  // ---------------------------------------------------------------- normalising dividers
  for (genvar g = 0; g < DivW; g++) begin : g_dv
    div_t sx_in, sy_in;
    if (g == 0) begin : g_first
      assign sx_in = pdx_q;
      assign sy_in = pdy_q;
    end else begin : g_next
      assign sx_in = dvx_q[g-1];
      assign sy_in = dvy_q[g-1];
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dvx_q[g] <= div_step(sx_in);
        dvy_q[g] <= div_step(sy_in);
      end
    end
  end

  // ---------------------------------------------------------------- axis dividers, three lanes
  for (genvar g = 0; g < QSteps; g++) begin : g_dq
    for (genvar k = 0; k < 3; k++) begin : g_lane
      div_t st_in;
      if (g == 0) begin : g_first
        assign st_in = kd_q[k];
      end else begin : g_next
        assign st_in = dq_q[g-1][k];
      end
      always_ff @(posedge clk_i) begin
        if (adv) begin
          dq_q[g][k] <= div_step(st_in);
        end
      end
    end
  end

  // ---------------------------------------------------------------- output register
  logic                  degen_d;
  logic [InW-1:0]        qmag [3];
  logic signed [InW-1:0] qval [3];

  always_comb begin
    degen_d = side_q[OStage-1].s < RootW'(1 << (Wq - FracBits - 1));
    for (int unsigned k = 0; k < 3; k++) begin
      if (side_q[OStage-1].qsat[k]
          || dq_q[QSteps-1][k].nq[QSteps-1:0] > QSteps'(QOne)) begin
        qmag[k] = QOne;
      end else begin
        qmag[k] = InW'(dq_q[QSteps-1][k].nq[QSteps-1:0]);
      end
      if (degen_d) begin
        qval[k] = '0;
      end else if (side_q[OStage-1].qsign[k]) begin
        qval[k] = -$signed(qmag[k]);
      end else begin
        qval[k] = $signed(qmag[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      quat_w_q <= $signed(side_q[OStage-1].w);
      quat_x_q <= qval[0];
      quat_y_q <= qval[1];
      quat_z_q <= qval[2];
      angle_q  <= side_q[OStage-1].angle;
      degen_q  <= degen_d;
    end
  end

  assign out_valid_o  = valid_q[Depth-1];
  assign quat_w_o     = quat_w_q;
  assign quat_x_o     = quat_x_q;
  assign quat_y_o     = quat_y_q;
  assign quat_z_o     = quat_z_q;
  assign angle_o      = angle_q;
  assign degenerate_o = degen_q;

endmodule
